/* hdl/onew_pkg.sv */
`timescale 1ns / 1ps

package onew_pkg;

    localparam int TICK_W    = 16;
    localparam int BYTE_W    = 8;
    localparam int ACT_W     = 2;
    localparam int BIT_IDX_W = 3;
    localparam int CFG_IDX_W = 3;

    localparam logic [ACT_W-1:0] ACT_RESET = 2'd0;
    localparam logic [ACT_W-1:0] ACT_WRITE = 2'd1;
    localparam logic [ACT_W-1:0] ACT_READ  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_RESET_LOW     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PRESENCE_WAIT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_START_LOW     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SLOT_HOLD     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_RECOVERY      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_READ_SAMPLE   = 3'd5;

    localparam logic [TICK_W-1:0] RST_RESET_LOW     = 16'd600;
    localparam logic [TICK_W-1:0] RST_PRESENCE_WAIT = 16'd60;
    localparam logic [TICK_W-1:0] RST_START_LOW     = 16'd2;
    localparam logic [TICK_W-1:0] RST_SLOT_HOLD     = 16'd60;
    localparam logic [TICK_W-1:0] RST_RECOVERY      = 16'd10;
    localparam logic [TICK_W-1:0] RST_READ_SAMPLE   = 16'd2;

    typedef struct packed {
        logic [TICK_W-1:0] reset_low_ticks;
        logic [TICK_W-1:0] presence_wait_ticks;
        logic [TICK_W-1:0] start_low_ticks;
        logic [TICK_W-1:0] slot_hold_ticks;
        logic [TICK_W-1:0] recovery_ticks;
        logic [TICK_W-1:0] read_sample_ticks;
    } t_cfg;

    typedef struct packed {
        logic              start_req;
        logic [ACT_W-1:0]  action;
        logic [BYTE_W-1:0] write_byte;
        logic              line_level;
    } t_in_item;

    typedef struct packed {
        logic              line_release;
        logic              busy_res;
        logic              done_res;
        logic              presence_found;
        logic [BYTE_W-1:0] read_byte;
    } t_out_item;

    // A zero duration counts as one tick.
    function automatic logic [TICK_W-1:0] dur(input logic [TICK_W-1:0] v);
        dur = (v == '0) ? {{(TICK_W-1){1'b0}}, 1'b1} : v;
    endfunction

endpackage

/* hdl/onew_if.sv */
`timescale 1ns / 1ps

interface onew_in_if;
    logic                        valid;
    logic                        ready;
    logic                        start_req;
    logic [onew_pkg::ACT_W-1:0]  action;
    logic [onew_pkg::BYTE_W-1:0] write_byte;
    logic                        line_level;

    modport source (output valid, start_req, action, write_byte, line_level, input ready);
    modport sink (input valid, start_req, action, write_byte, line_level, output ready);
endinterface

interface onew_out_if;
    logic                        valid;
    logic                        ready;
    logic                        line_release;
    logic                        busy_res;
    logic                        done_res;
    logic                        presence_found;
    logic [onew_pkg::BYTE_W-1:0] read_byte;

    modport source (output valid, line_release, busy_res, done_res, presence_found, read_byte,
                    input ready);
    modport sink (input valid, line_release, busy_res, done_res, presence_found, read_byte,
                  output ready);
endinterface

interface onew_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [onew_pkg::CFG_IDX_W-1:0] index;
    logic [onew_pkg::TICK_W-1:0]    data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

/* hdl/one_wire_byte_master_core.sv */
`timescale 1ns / 1ps

// One-wire bus master, one input transfer per timebase tick.
// i_in carries the tick: start request, action (bus reset with presence detect,
// write byte, read byte), the byte to write and the sampled line level.
// o_out returns exactly one result per input transfer: the line drive for that
// tick, busy and done flags, the last presence answer and the last byte read.
// i_cfg writes the six timing registers by index; it is always ready and should
// only be used while no action is running.
// Each input tick passes the input register and then the two-entry result buffer
// before its result is offered on o_out. The block takes one input transfer every
// cycle while the result buffer has space; the tick state machine computes each
// result combinationally from the input register into the result buffer.
// When the receiver stalls, the buffer holds up to two results and the input
// register one more tick before i_in.ready falls; nothing is dropped.
// Reset returns all timing registers to their defaults, puts the master in the
// idle phase with cleared presence and read byte, and empties both buffers.
module one_wire_byte_master_core (
    input  logic       i_clk,
    input  logic       i_rst_n,
    onew_in_if.sink    i_in,
    onew_out_if.source o_out,
    onew_cfg_if.sink   i_cfg
);
    import onew_pkg::*;

    t_cfg      cfg;
    t_in_item  r_item;
    t_out_item res;
    logic      r_in_valid;
    logic      buf_space;
    logic      step;

    assign step     = r_in_valid && buf_space;
    assign i_in.ready = !r_in_valid || step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_item.start_req  <= i_in.start_req;
            r_item.action     <= i_in.action;
            r_item.write_byte <= i_in.write_byte;
            r_item.line_level <= i_in.line_level;
        end
    end

    onew_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (cfg)
    );

    onew_fsm u_fsm (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (step),
        .i_item  (r_item),
        .i_cfg   (cfg),
        .o_res   (res)
    );

    onew_out_buf u_buf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (step),
        .i_item  (res),
        .o_space (buf_space),
        .o_out   (o_out)
    );

`ifndef SYNTH
    a_in_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !buf_space) |=> r_in_valid)
        else $error("buffered input tick lost while result buffer full");

    a_done_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (step && res.done_res) |-> res.busy_res)
        else $error("done without busy");

    a_idle_release: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (step && !res.busy_res) |-> res.line_release)
        else $error("line driven low while idle");

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && !o_out.ready && !buf_space) |=> o_out.valid)
        else $error("result buffer emptied while stalled");
`endif

endmodule

/* hdl/onew_cfg_regs.sv */
`timescale 1ns / 1ps

module onew_cfg_regs (
    input  logic         i_clk,
    input  logic         i_rst_n,
    onew_cfg_if.sink     i_cfg,
    output onew_pkg::t_cfg o_cfg
);
    import onew_pkg::*;

    t_cfg r_cfg;
    t_cfg n_cfg;

    assign i_cfg.ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg.valid) begin
            case (i_cfg.index)
                REG_RESET_LOW:     n_cfg.reset_low_ticks     = i_cfg.data;
                REG_PRESENCE_WAIT: n_cfg.presence_wait_ticks = i_cfg.data;
                REG_START_LOW:     n_cfg.start_low_ticks     = i_cfg.data;
                REG_SLOT_HOLD:     n_cfg.slot_hold_ticks     = i_cfg.data;
                REG_RECOVERY:      n_cfg.recovery_ticks      = i_cfg.data;
                REG_READ_SAMPLE:   n_cfg.read_sample_ticks   = i_cfg.data;
                default:           n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.reset_low_ticks     <= RST_RESET_LOW;
            r_cfg.presence_wait_ticks <= RST_PRESENCE_WAIT;
            r_cfg.start_low_ticks     <= RST_START_LOW;
            r_cfg.slot_hold_ticks     <= RST_SLOT_HOLD;
            r_cfg.recovery_ticks      <= RST_RECOVERY;
            r_cfg.read_sample_ticks   <= RST_READ_SAMPLE;
        end else begin
            r_cfg <= n_cfg;
        end
    end

endmodule

/* hdl/onew_fsm.sv */
`timescale 1ns / 1ps

module onew_fsm (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_step,
    input  onew_pkg::t_in_item   i_item,
    input  onew_pkg::t_cfg       i_cfg,
    output onew_pkg::t_out_item  o_res
);
    import onew_pkg::*;

    localparam logic [3:0] PH_IDLE     = 4'd0;
    localparam logic [3:0] PH_RST_LOW  = 4'd1;
    localparam logic [3:0] PH_RST_WAIT = 4'd2;
    localparam logic [3:0] PH_RST_HIGH = 4'd3;
    localparam logic [3:0] PH_BIT_LOW  = 4'd4;
    localparam logic [3:0] PH_WR_HOLD  = 4'd5;
    localparam logic [3:0] PH_WR_REC   = 4'd6;
    localparam logic [3:0] PH_RD_REL   = 4'd7;
    localparam logic [3:0] PH_RD_WAIT  = 4'd8;

    logic [3:0]           r_phase, n_phase;
    logic [TICK_W-1:0]    r_tick, n_tick;
    logic [BIT_IDX_W-1:0] r_bit, n_bit;
    logic [BYTE_W-1:0]    r_shift, n_shift;
    logic [ACT_W-1:0]     r_act, n_act;
    logic                 r_pres, n_pres;
    logic [BYTE_W-1:0]    r_rx, n_rx;

    logic              start_hit;
    logic              level;
    logic              busy;
    logic              done;
    logic              fin;
    logic              tick_end;
    logic [TICK_W-1:0] tick_inc;
    logic [TICK_W-1:0] len;

    always_comb begin
        n_phase = r_phase;
        n_tick  = r_tick;
        n_bit   = r_bit;
        n_shift = r_shift;
        n_act   = r_act;
        n_pres  = r_pres;
        n_rx    = r_rx;
        level   = 1'b1;
        done    = 1'b0;
        fin     = 1'b0;

        start_hit = (r_phase == PH_IDLE) && i_item.start_req
                    && (i_item.action inside {ACT_RESET, ACT_WRITE, ACT_READ});
        if (start_hit) begin
            n_act   = i_item.action;
            n_bit   = '0;
            n_shift = (i_item.action == ACT_WRITE) ? i_item.write_byte : '0;
            n_phase = (i_item.action == ACT_RESET) ? PH_RST_LOW : PH_BIT_LOW;
            n_tick  = '0;
        end

        case (n_phase)
            PH_RST_LOW:  len = dur(i_cfg.reset_low_ticks);
            PH_RST_WAIT: len = dur(i_cfg.presence_wait_ticks);
            PH_BIT_LOW:  len = dur(i_cfg.start_low_ticks);
            PH_WR_HOLD:  len = dur(i_cfg.slot_hold_ticks);
            PH_WR_REC:   len = i_cfg.recovery_ticks;
            PH_RD_REL:   len = dur(i_cfg.read_sample_ticks);
            PH_RD_WAIT:  len = dur(i_cfg.slot_hold_ticks);
            default:     len = dur('0);
        endcase

        tick_inc = n_tick + TICK_W'(1);
        tick_end = (tick_inc >= len);
        busy     = (n_phase != PH_IDLE);

        case (n_phase)
            PH_IDLE: begin
                busy = 1'b0;
            end
            PH_RST_LOW: begin
                level   = 1'b0;
                n_tick  = tick_end ? '0 : tick_inc;
                n_phase = tick_end ? PH_RST_WAIT : PH_RST_LOW;
            end
            PH_RST_WAIT: begin
                n_tick  = tick_end ? '0 : tick_inc;
                n_phase = tick_end ? PH_RST_HIGH : PH_RST_WAIT;
            end
            PH_RST_HIGH: begin
                if (n_tick == '0) begin
                    n_pres = !i_item.line_level;
                    n_tick = {{(TICK_W-1){1'b0}}, 1'b1};
                end
                if (i_item.line_level) begin
                    done    = 1'b1;
                    n_phase = PH_IDLE;
                    n_tick  = '0;
                end
            end
            PH_BIT_LOW: begin
                level  = 1'b0;
                n_tick = tick_end ? '0 : tick_inc;
                if (tick_end) begin
                    n_phase = (n_act == ACT_WRITE) ? PH_WR_HOLD : PH_RD_REL;
                end
            end
            PH_WR_HOLD: begin
                level  = n_shift[n_bit];
                n_tick = tick_inc;
                if (tick_end) begin
                    if (i_cfg.recovery_ticks == '0) begin
                        fin = 1'b1;
                    end else begin
                        n_phase = PH_WR_REC;
                        n_tick  = '0;
                    end
                end
            end
            PH_WR_REC: begin
                n_tick = tick_inc;
                fin    = tick_end;
            end
            PH_RD_REL: begin
                n_tick  = tick_end ? '0 : tick_inc;
                n_phase = tick_end ? PH_RD_WAIT : PH_RD_REL;
            end
            PH_RD_WAIT: begin
                if ((n_tick == '0) && i_item.line_level) begin
                    n_shift = n_shift | (BYTE_W'(1) << n_bit);
                end
                n_tick = tick_inc;
                fin    = tick_end;
            end
            default: begin
                busy    = 1'b0;
                n_phase = PH_IDLE;
                n_tick  = '0;
            end
        endcase

        if (fin) begin
            n_tick = '0;
            if (n_bit == '1) begin
                if (n_act == ACT_READ) begin
                    n_rx = n_shift;
                end
                n_phase = PH_IDLE;
                done    = 1'b1;
            end else begin
                n_bit   = n_bit + BIT_IDX_W'(1);
                n_phase = PH_BIT_LOW;
            end
        end
    end

    assign o_res.line_release   = level;
    assign o_res.busy_res       = busy;
    assign o_res.done_res       = done;
    assign o_res.presence_found = n_pres;
    assign o_res.read_byte      = n_rx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_tick  <= '0;
            r_bit   <= '0;
            r_shift <= '0;
            r_act   <= ACT_RESET;
            r_pres  <= 1'b0;
            r_rx    <= '0;
        end else if (i_step) begin
            r_phase <= n_phase;
            r_tick  <= n_tick;
            r_bit   <= n_bit;
            r_shift <= n_shift;
            r_act   <= n_act;
            r_pres  <= n_pres;
            r_rx    <= n_rx;
        end
    end

endmodule

/* hdl/onew_out_buf.sv */
`timescale 1ns / 1ps

module onew_out_buf (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  onew_pkg::t_out_item i_item,
    output logic                o_space,
    onew_out_if.source          o_out
);
    import onew_pkg::*;

    t_out_item  r_q0;
    t_out_item  r_q1;
    logic [1:0] r_cnt, n_cnt;
    logic       pop;

    assign o_space = (r_cnt != 2'd2);
    assign pop     = o_out.valid && o_out.ready;

    assign o_out.valid          = (r_cnt != 2'd0);
    assign o_out.line_release   = r_q0.line_release;
    assign o_out.busy_res       = r_q0.busy_res;
    assign o_out.done_res       = r_q0.done_res;
    assign o_out.presence_found = r_q0.presence_found;
    assign o_out.read_byte      = r_q0.read_byte;

    assign n_cnt = r_cnt + {1'b0, i_push} - {1'b0, pop};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop) begin
            if (r_cnt == 2'd2) begin
                r_q0 <= r_q1;
            end else if (i_push) begin
                r_q0 <= i_item;
            end
        end else if (i_push) begin
            if (r_cnt == 2'd0) begin
                r_q0 <= i_item;
            end else begin
                r_q1 <= i_item;
            end
        end
    end

endmodule
